// ----- rtl/edd_pkg.sv -----
// ============================================================================
// edd_pkg
// Shared types and constants for the edit distance engine and its cells.
// ============================================================================
`default_nettype none

package edd_pkg;

   // request commands
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_QUERY = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   localparam int SYM_W  = 8;
   localparam int DIST_W = 7;

   // query symbol moving along the cell chain
   typedef struct packed {
      logic             valid;
      logic [SYM_W-1:0] symbol;
   } tok_type;

   // control sequencer, one-hot
   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/edd_cell.sv -----
// ============================================================================
// edd_cell
// One reference position of the systolic chain: holds a reference byte and
// the DP row entry for that position, updates it as a query symbol passes.
// ============================================================================
`default_nettype none

module edd_cell #(
   parameter int ROW_W = 7,
   parameter int IDX   = 1
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          init_i,
   input  wire                          wr_en_i,
   input  wire  [edd_pkg::SYM_W-1:0]    wr_sym_i,
   input  wire  edd_pkg::tok_type       tok_i,
   input  wire  [ROW_W-1:0]             left_i,
   input  wire  [ROW_W-1:0]             diag_i,
   output edd_pkg::tok_type             tok_o,
   output logic [ROW_W-1:0]             left_o,
   output logic [ROW_W-1:0]             diag_o,
   output logic [ROW_W-1:0]             row_o
);

   logic [edd_pkg::SYM_W-1:0] ref_ff;
   logic [ROW_W-1:0]          row_ff;
   logic                      vld_ff;
   logic [edd_pkg::SYM_W-1:0] sym_ff;
   logic [ROW_W-1:0]          left_ff;
   logic [ROW_W-1:0]          diag_ff;

   logic                      cost;
   logic [ROW_W-1:0]          ul_min;
   logic [ROW_W:0]            diag_sum;
   logic [ROW_W:0]            ul_sum;
   logic [ROW_W:0]            best_w;
   logic [ROW_W-1:0]          best;

   // min(diag + cost, min(up, left) + 1), one guard bit on the sums
   always_comb begin
      cost     = (ref_ff != tok_i.symbol);
      ul_min   = (row_ff < left_i) ? row_ff : left_i;
      diag_sum = {1'b0, diag_i} + {{ROW_W{1'b0}}, cost};
      ul_sum   = {1'b0, ul_min} + (ROW_W+1)'(1);
      best_w   = (diag_sum < ul_sum) ? diag_sum : ul_sum;
      best     = best_w[ROW_W-1:0];
   end

   // reference byte
   always_ff @(posedge clock) begin
      if (wr_en_i) begin
         ref_ff <= wr_sym_i;
      end
   end

   // row entry and hand-off to the next cell
   always_ff @(posedge clock) begin
      if (init_i) begin
         row_ff <= ROW_W'(IDX);
      end else if (tok_i.valid) begin
         row_ff <= best;
      end
      if (tok_i.valid) begin
         sym_ff  <= tok_i.symbol;
         left_ff <= best;
         diag_ff <= row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= tok_i.valid;
      end
   end

   assign tok_o.valid  = vld_ff;
   assign tok_o.symbol = sym_ff;
   assign left_o       = left_ff;
   assign diag_o       = diag_ff;
   assign row_o        = row_ff;

endmodule

`default_nettype wire

// ----- rtl/edit_distance_engine.sv -----
// ============================================================================
// edit_distance_engine
// Levenshtein distance between a stored reference and a streamed query.
// ============================================================================
// Usage:
//  - req_ channel, one beat per byte: command load stores a reference byte,
//    query advances the DP row by one query byte, end closes the query.
//    last on a load closes the reference; last on a query closes the query.
//  - rsp_ channel carries one beat per closed query: distance and a sticky
//    overflow flag (reference or a query went past MAX_LEN bytes).
//  - Reference and query bytes are taken one per cycle while req_ready
//    is high. Each query byte travels down a chain of MAX_LEN cells, one
//    cell per cycle, so a row update needs no long combinational path.
//  - Closing a query holds off req_ until the chain has drained, then the
//    result is registered: rsp_valid rises once the chain is empty, or
//    later while an earlier result still waits for rsp_ready.
//    A load also waits for the chain to drain.
//  - A query arriving before the reference was closed is held while it
//    closes the reference at its current length.
//  - A waiting result does not block the next query; only the next result
//    capture waits for rsp_ready.
//  - Reset (synchronous) empties the chain and clears reference length,
//    query count and flags; stored bytes are left as they are.
// ============================================================================
`default_nettype none

module edit_distance_engine #(
   parameter int MAX_LEN = 64
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire  [1:0]                      req_command,
   input  wire  [edd_pkg::SYM_W-1:0]       req_symbol,
   input  wire                             req_last,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic [edd_pkg::DIST_W-1:0]      rsp_distance,
   output logic                            rsp_overflow
);

   localparam int ROW_W = $clog2(MAX_LEN + 1);

   edd_pkg::state_type              state_ff, state_in;
   logic                            ref_done_ff, ref_done_in;
   logic [ROW_W-1:0]                len_ff, len_in;
   logic [ROW_W-1:0]                qcount_ff, qcount_in;
   logic                            ovf_ff, ovf_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [edd_pkg::DIST_W-1:0]      rsp_distance_ff;
   logic                            rsp_overflow_ff;

   logic                            run;
   logic                            accept;
   logic                            close_imp;
   logic                            inject;
   logic                            ref_wr;
   logic                            init_all;
   logic                            capture;
   logic                            busy;
   logic [ROW_W-1:0]                wr_idx;
   logic [ROW_W-1:0]                end_val;

   edd_pkg::tok_type                tok   [0:MAX_LEN];
   logic [ROW_W-1:0]                left  [0:MAX_LEN];
   logic [ROW_W-1:0]                diag  [0:MAX_LEN];
   logic [ROW_W-1:0]                tap   [0:MAX_LEN];
   logic [ROW_W-1:0]                row_q [0:MAX_LEN-1];

   assign run    = (state_ff == edd_pkg::ST_RUN);
   assign accept = req_valid & req_ready;

   // handshake: nothing is taken while draining; loads wait for an empty chain, queries and ends for a closed reference
   always_comb begin
      case (req_command)
         edd_pkg::CMD_LOAD:  req_ready = run & ~busy;
         edd_pkg::CMD_QUERY: req_ready = run & ref_done_ff;
         edd_pkg::CMD_END:   req_ready = run & ref_done_ff;
         default:            req_ready = run;
      endcase
   end

   assign close_imp = req_valid & run & ~ref_done_ff &
                      ((req_command == edd_pkg::CMD_QUERY) ||
                       (req_command == edd_pkg::CMD_END));

   // sequencer
   always_comb begin
      state_in    = state_ff;
      ref_done_in = ref_done_ff;
      len_in      = len_ff;
      qcount_in   = qcount_ff;
      ovf_in      = ovf_ff;
      inject      = 1'b0;
      ref_wr      = 1'b0;
      init_all    = 1'b0;
      wr_idx      = ref_done_ff ? '0 : len_ff;

      // query before close: close the reference first, beat stays pending
      if (close_imp) begin
         ref_done_in = 1'b1;
         qcount_in   = '0;
         init_all    = 1'b1;
      end

      if (accept) begin
         case (req_command)
            edd_pkg::CMD_LOAD: begin
               // a load after close starts a new reference
               if (ref_done_ff) begin
                  ref_done_in = 1'b0;
                  qcount_in   = '0;
                  ovf_in      = 1'b0;
               end
               if (wr_idx < ROW_W'(MAX_LEN)) begin
                  ref_wr = 1'b1;
                  len_in = wr_idx + ROW_W'(1);
               end else begin
                  len_in = wr_idx;
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  ref_done_in = 1'b1;
                  qcount_in   = '0;
                  init_all    = 1'b1;
               end
            end
            edd_pkg::CMD_QUERY: begin
               if (qcount_ff < ROW_W'(MAX_LEN)) begin
                  inject    = 1'b1;
                  qcount_in = qcount_ff + ROW_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  state_in = edd_pkg::ST_DRAIN;
               end
            end
            edd_pkg::CMD_END: begin
               state_in = edd_pkg::ST_DRAIN;
            end
            default: begin
            end
         endcase
      end

      // result capture once the wavefront has left the chain
      capture = (state_ff == edd_pkg::ST_DRAIN) & ~busy &
                (~rsp_valid_ff | rsp_ready);
      if (capture) begin
         state_in  = edd_pkg::ST_RUN;
         qcount_in = '0;
         init_all  = 1'b1;
      end

      rsp_valid_in = capture | (rsp_valid_ff & ~rsp_ready);
   end

   // chain head: row entry zero is the query count
   assign tok[0].valid  = inject;
   assign tok[0].symbol = req_symbol;
   assign left[0]       = qcount_ff + ROW_W'(1);
   assign diag[0]       = qcount_ff;
   assign tap[0]        = (len_ff == '0) ? qcount_ff : '0;

   // cell chain
   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      edd_cell #(
         .ROW_W (ROW_W),
         .IDX   (i + 1)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .init_i   (init_all),
         .wr_en_i  (ref_wr & (wr_idx == ROW_W'(i))),
         .wr_sym_i (req_symbol),
         .tok_i    (tok[i]),
         .left_i   (left[i]),
         .diag_i   (diag[i]),
         .tok_o    (tok[i+1]),
         .left_o   (left[i+1]),
         .diag_o   (diag[i+1]),
         .row_o    (row_q[i])
      );
      // the cell at the reference end drives the result
      assign tap[i+1] = (len_ff == ROW_W'(i + 1)) ? row_q[i] : '0;
   end

   // chain occupancy and end-of-row value
   always_comb begin
      busy    = 1'b0;
      end_val = '0;
      for (int k = 1; k <= MAX_LEN; k++) begin
         busy = busy | tok[k].valid;
      end
      for (int k = 0; k <= MAX_LEN; k++) begin
         end_val = end_val | tap[k];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= edd_pkg::ST_RUN;
         ref_done_ff  <= 1'b0;
         len_ff       <= '0;
         qcount_ff    <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ref_done_ff  <= ref_done_in;
         len_ff       <= len_in;
         qcount_ff    <= qcount_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (capture) begin
         rsp_distance_ff <= edd_pkg::DIST_W'(end_val);
         rsp_overflow_ff <= ovf_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_overflow = rsp_overflow_ff;

   // checks
   a_no_inject_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == edd_pkg::ST_DRAIN) |-> !inject)
      else $error("query beat injected while draining");

   a_capture_empty: assert property (@(posedge clock) disable iff (reset)
      capture |-> !busy)
      else $error("result captured with chain busy");

   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      ref_wr |-> (!busy && !inject))
      else $error("reference write with chain busy");

   a_qcount_range: assert property (@(posedge clock) disable iff (reset)
      qcount_ff <= ROW_W'(MAX_LEN))
      else $error("query count past MAX_LEN");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= ROW_W'(MAX_LEN))
      else $error("reference length past MAX_LEN");

endmodule

`default_nettype wire
